// File: design/fat12_pkg.sv
// FAT12 cluster table engine: shared constants and command codes.
// No dependencies.
package fat12_pkg;
  localparam int TableBytes = 8192;
  localparam int AddrW = $clog2(TableBytes);
  localparam logic [11:0] EndMark = 12'hFFF;
  localparam logic [11:0] ChainEndMin = 12'hFF8;
  localparam logic [11:0] FreedMax = 12'hFFF;
  localparam logic [11:0] LimitReset = 12'd4088;

  typedef enum logic [2:0] {
    CMD_RD_BYTE = 3'd0,
    CMD_WR_BYTE = 3'd1,
    CMD_GET     = 3'd2,
    CMD_SET     = 3'd3,
    CMD_ALLOC   = 3'd4,
    CMD_FREE    = 3'd5
  } cmd_t;
endpackage

// File: design/fat12_cluster_table_engine_unit.sv
// FAT12 cluster table engine top level: command sequencer over a byte RAM.
// Depends on fat12_pkg and fat12_ram.
//
// channel | ports                                             | dir
// in      | in_valid in_stall in_command in_byte_addr ...     | request in
// out     | out_valid out_stall out_byte_out out_entry_out ...| result out
// cfg     | cfg_we cfg_wdata                                  | write only
//
// Allocate scans the entries until it finds a free one, marks the new entry
// end of chain, links it from the given cluster when that is nonzero, then
// posts the result; free clears each entry of the chain in turn. One RAM port:
// an entry access reads two bytes, and an entry update writes two back.
// Reset: sync active low; table contents are undefined until written.
// A stalled result holds; a new request is taken the cycle after it leaves.
module fat12_cluster_table_engine_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  in_command,
  input  logic [12:0] in_byte_addr,
  input  logic [7:0]  in_byte_in,
  input  logic [11:0] in_cluster,
  input  logic [11:0] in_entry_value,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [7:0]  out_byte_out,
  output logic [11:0] out_entry_out,
  output logic [11:0] out_freed_count,
  output logic        out_status,
  input  logic        cfg_we,
  input  logic [11:0] cfg_wdata
);
  import fat12_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_RD0, S_RD1, S_RD2, S_WR0, S_WR1, S_DONE
  } state_t;
  typedef enum logic [1:0] {
    P_GET, P_SET, P_ALLOC_SCAN, P_FREE
  } phase_t;

  state_t      state_r;
  phase_t      phase_r;
  logic [2:0]  cmd_r;
  logic [12:0] baddr_r;
  logic [7:0]  bin_r;
  logic [11:0] cl_r, ev_r, cur_r, found_r, freed_r, lim_r, entry_r;
  logic [11:0] wval_r;
  logic        link_r;
  logic [7:0]  lo_r, hi_r;
  logic        out_valid_r;
  logic [7:0]  ob_r;
  logic [11:0] oe_r, of_r;
  logic        os_r;

  logic        ram_we;
  logic [AddrW-1:0] ram_addr;
  logic [7:0]  ram_wd, ram_rd;

  fat12_ram #(.Width(8), .Depth(TableBytes)) u_ram (
    .clk(clk), .we(ram_we), .addr(ram_addr), .wdata(ram_wd), .rdata(ram_rd)
  );

  logic [13:0] off;
  logic [13:0] off1;
  logic [11:0] ent;
  logic [15:0] w_new;
  logic [11:0] bound;
  logic        alloc_none;
  assign off   = {2'b0, cur_r} + {3'b0, cur_r[11:1]};
  assign off1  = off + 14'd1;
  assign ent   = cur_r[0] ? {hi_r, lo_r[7:4]} : {hi_r[3:0], lo_r};
  assign w_new = cur_r[0] ? {wval_r, lo_r[3:0]} : {hi_r[7:4], wval_r};
  assign bound = (lim_r < ChainEndMin) ? lim_r : ChainEndMin;
  assign alloc_none = (bound <= 12'd2);

  logic off_ok, off1_ok;
  assign off_ok  = off  < 14'(TableBytes);
  assign off1_ok = off1 < 14'(TableBytes);

  always_comb begin
    ram_we   = 1'b0;
    ram_addr = baddr_r[AddrW-1:0];
    ram_wd   = bin_r;
    case (state_r)
      S_RD0: if (cmd_r != CMD_RD_BYTE && cmd_r != CMD_WR_BYTE) begin
        ram_addr = off[AddrW-1:0];
      end else if (cmd_r == CMD_WR_BYTE) begin
        ram_we = 1'b1;
      end
      S_RD1: ram_addr = off1[AddrW-1:0];
      S_WR0: begin
        ram_addr = off[AddrW-1:0];
        ram_wd   = w_new[7:0];
        // busy entry during the allocate scan stays untouched
        ram_we   = off_ok && !(phase_r == P_ALLOC_SCAN && ent != 12'd0);
      end
      S_WR1: begin
        ram_addr = off1[AddrW-1:0];
        ram_wd   = w_new[15:8];
        ram_we   = off1_ok;
      end
      default: ;
    endcase
  end

  assign in_stall = !rst_n || (state_r != S_IDLE) || out_valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      lim_r       <= LimitReset;
    end else begin
      if (cfg_we) lim_r <= cfg_wdata;
      if (out_valid_r && !out_stall) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: if (in_valid && !in_stall) begin
          cmd_r   <= in_command;
          baddr_r <= in_byte_addr;
          bin_r   <= in_byte_in;
          cl_r    <= in_cluster;
          ev_r    <= in_entry_value;
          freed_r <= '0;
          found_r <= '0;
          link_r  <= 1'b0;
          ob_r <= '0; oe_r <= '0; of_r <= '0;
          os_r <= (in_command == CMD_ALLOC) && alloc_none;
          case (in_command)
            CMD_GET:   begin cur_r <= in_cluster; phase_r <= P_GET;  end
            CMD_SET:   begin cur_r <= in_cluster; phase_r <= P_SET;  end
            CMD_ALLOC: begin cur_r <= 12'd2; phase_r <= P_ALLOC_SCAN; end
            CMD_FREE:  begin cur_r <= in_cluster; phase_r <= P_FREE; end
            default: ;
          endcase
          if (in_command == CMD_ALLOC && alloc_none)
            state_r <= S_DONE;
          else if (in_command == CMD_FREE &&
                   !(in_cluster >= 12'd2 && in_cluster < ChainEndMin))
            state_r <= S_DONE;
          else if (in_command <= CMD_FREE)
            state_r <= S_RD0;
          else
            state_r <= S_DONE;
        end
        S_RD0: begin
          if (cmd_r == CMD_RD_BYTE || cmd_r == CMD_WR_BYTE) state_r <= S_RD2;
          else state_r <= S_RD1;
        end
        S_RD1: begin
          lo_r    <= off_ok ? ram_rd : 8'd0;
          state_r <= S_RD2;
        end
        S_RD2: begin
          if (cmd_r == CMD_RD_BYTE) begin
            ob_r <= ram_rd; state_r <= S_DONE;
          end else if (cmd_r == CMD_WR_BYTE) begin
            state_r <= S_DONE;
          end else begin
            hi_r <= off1_ok ? ram_rd : 8'd0;
            case (phase_r)
              P_GET: state_r <= S_DONE;
              P_SET: begin
                wval_r  <= link_r ? found_r : ev_r;
                state_r <= S_WR0;
              end
              P_FREE: begin
                wval_r  <= '0;
                state_r <= S_WR0;
              end
              default: begin
                wval_r  <= EndMark;
                state_r <= S_WR0;
              end
            endcase
          end
          if (phase_r == P_GET && cmd_r == CMD_GET)
            oe_r <= cur_r[0] ? {ram_rd, lo_r[7:4]} : {ram_rd[3:0], lo_r};
        end
        S_WR0: begin
          if (phase_r == P_ALLOC_SCAN && ent != 12'd0) begin
            if (cur_r + 12'd1 >= bound) begin
              os_r <= 1'b1; state_r <= S_DONE;
            end else begin
              cur_r <= cur_r + 12'd1; state_r <= S_RD0;
            end
          end else begin
            state_r <= S_WR1;
            if (phase_r == P_FREE) entry_r <= ent;
          end
        end
        S_WR1: begin
          case (phase_r)
            P_ALLOC_SCAN: begin
              found_r <= cur_r; oe_r <= cur_r;
              if (cl_r != 12'd0) begin
                link_r <= 1'b1; cur_r <= cl_r; phase_r <= P_SET;
                state_r <= S_RD0;
              end else begin
                state_r <= S_DONE;
              end
            end
            P_FREE: begin
              freed_r <= freed_r + 12'd1;
              of_r    <= freed_r + 12'd1;
              if (entry_r >= 12'd2 && entry_r < ChainEndMin &&
                  freed_r + 12'd1 < FreedMax) begin
                cur_r <= entry_r; state_r <= S_RD0;
              end else begin
                state_r <= S_DONE;
              end
            end
            default: state_r <= S_DONE;
          endcase
        end
        S_DONE: begin
          out_valid_r <= 1'b1;
          out_byte_out    <= ob_r;
          out_entry_out   <= oe_r;
          out_freed_count <= of_r;
          out_status      <= os_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid = out_valid_r;

`ifndef ASSERT_OFF
  a_one_owner: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("request taken under pending result");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> out_valid) else $error("result dropped");
  a_idle_nowr: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !ram_we) else $error("write while idle");
`endif
endmodule

// File: design/fat12_ram.sv
// Generic single-port RAM, registered read.
// No dependencies.
module fat12_ram #(
  parameter int Width = 8,
  parameter int Depth = 8192
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] addr,
  input  logic [Width-1:0]         wdata,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[addr] <= wdata;
    rdata <= mem[addr];
  end
endmodule

// File: verif/tb_fat12_cluster_table_engine_unit.sv
// Testbench for fat12_cluster_table_engine_unit: random and directed requests
// checked against an in-bench FAT12 table predictor. Depends on fat12_pkg.
module tb_fat12_cluster_table_engine_unit;
  import fat12_pkg::*;

  localparam logic [2:0] CmdSpareA = 3'd6;
  localparam logic [2:0] CmdSpareB = 3'd7;
  localparam int unsigned EvenKeep = 'hF000;
  localparam int unsigned OddKeep = 'h000F;
  localparam int FillBytes = 768;
  localparam int FillClusters = 512;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [12:0] addr;
    logic [7:0]  bval;
    logic [11:0] clus;
    logic [11:0] eval;
  } fat_req_t;

  typedef struct packed {
    logic [7:0]  bout;
    logic [11:0] eout;
    logic [11:0] freed;
    logic        st;
  } fat_rsp_t;

  logic        clk, rst_n;
  logic        in_valid, in_stall;
  logic [2:0]  in_command;
  logic [12:0] in_byte_addr;
  logic [7:0]  in_byte_in;
  logic [11:0] in_cluster, in_entry_value;
  logic        out_valid, out_stall;
  logic [7:0]  out_byte_out;
  logic [11:0] out_entry_out, out_freed_count;
  logic        out_status;
  logic        cfg_we;
  logic [11:0] cfg_wdata;

  logic [7:0]  fat_bytes [TableBytes];
  logic [11:0] fat_limit;
  fat_rsp_t    rsp_pending [$];
  int          mismatches;
  bit          steady;
  bit          hold_req;
  int          chain_head, chain_tail, chain_len;

  fat12_cluster_table_engine_unit DUT (.*);

  always begin
    clk = 1'b1; #5;
    clk = 1'b0; #5;
  end

  function automatic int unsigned fat_rd(int unsigned a);
    return (a < TableBytes) ? fat_bytes[a] : 0;
  endfunction

  function automatic void fat_wr(int unsigned a, int unsigned v);
    if (a < TableBytes) fat_bytes[a] = v[7:0];
  endfunction

  function automatic int unsigned fat_get(int unsigned c);
    int unsigned off, w;
    off = c + (c >> 1);
    w = fat_rd(off) | (fat_rd(off + 1) << 8);
    return (c & 1) ? (w >> 4) & 'hFFF : w & 'hFFF;
  endfunction

  function automatic void fat_set(int unsigned c, int unsigned v);
    int unsigned off, w;
    off = c + (c >> 1);
    w = fat_rd(off) | (fat_rd(off + 1) << 8);
    v = v & 'hFFF;
    if (c & 1) w = (w & OddKeep) | (v << 4);
    else w = (w & EvenKeep) | v;
    fat_wr(off, w & 'hFF);
    fat_wr(off + 1, (w >> 8) & 'hFF);
  endfunction

  function automatic int unsigned lowest_free();
    int unsigned bound;
    bound = (fat_limit < ChainEndMin) ? fat_limit : ChainEndMin;
    for (int unsigned c = 2; c < bound; c++)
      if (fat_get(c) == 0) return c;
    return 0;
  endfunction

  // a chain walk must stay inside the written region
  function automatic bit walk_safe(int unsigned c);
    bit seen [FillClusters];
    seen = '{default: 1'b0};
    while (c >= 2 && c < ChainEndMin) begin
      if (c >= FillClusters) return 1'b0;
      if (seen[c]) return 1'b1;
      seen[c] = 1'b1;
      c = fat_get(c);
    end
    return 1'b1;
  endfunction

  function automatic bit alloc_safe();
    int unsigned f, bound;
    bound = (fat_limit < ChainEndMin) ? fat_limit : ChainEndMin;
    f = lowest_free();
    return (f != 0) ? (f < FillClusters) : (bound <= FillClusters);
  endfunction

  function automatic fat_rsp_t fat_predict(fat_req_t r);
    fat_rsp_t    p;
    int unsigned c, nxt, found;
    p = '0;
    case (r.cmd)
      CMD_RD_BYTE: p.bout = 8'(fat_rd(r.addr));
      CMD_WR_BYTE: fat_wr(r.addr, r.bval);
      CMD_GET:     p.eout = 12'(fat_get(r.clus));
      CMD_SET:     fat_set(r.clus, r.eval);
      CMD_ALLOC: begin
        found = lowest_free();
        if (found != 0) begin
          fat_set(found, EndMark);
          if (r.clus != 0) fat_set(r.clus, found);
          p.eout = 12'(found);
        end else p.st = 1'b1;
      end
      CMD_FREE: begin
        c = r.clus;
        while (c >= 2 && c < ChainEndMin && p.freed < FreedMax) begin
          nxt = fat_get(c);
          fat_set(c, 0);
          p.freed++;
          c = nxt;
        end
      end
      default: ;
    endcase
    return p;
  endfunction

  task automatic send_req(fat_req_t r, output fat_rsp_t p);
    while (!steady && $urandom_range(99) < 18) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid       <= 1'b1;
    in_command     <= r.cmd;
    in_byte_addr   <= r.addr;
    in_byte_in     <= r.bval;
    in_cluster     <= r.clus;
    in_entry_value <= r.eval;
    do @(posedge clk); while (in_stall);
    p = fat_predict(r);
    rsp_pending.push_back(p);
  endtask

  task automatic issue(logic [2:0] cmd, int unsigned addr = 0, int unsigned bval = 0,
                       int unsigned clus = 0, int unsigned eval = 0);
    fat_req_t r;
    fat_rsp_t p;
    r = '{cmd, addr[12:0], bval[7:0], clus[11:0], eval[11:0]};
    send_req(r, p);
  endtask

  task automatic write_limit(int unsigned v);
    in_valid <= 1'b0;
    @(posedge clk);
    wait (rsp_pending.size() == 0);
    repeat (4) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v[11:0];
    @(posedge clk);
    cfg_we    <= 1'b0;
    fat_limit = v[11:0];
  endtask

  // receiver: random stalls, or one long hold when asked
  initial begin
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (400) @(posedge clk);
        hold_req = 1'b0;
        out_stall <= 1'b0;
      end else begin
        out_stall <= !steady && ($urandom_range(99) < 18);
      end
    end
  end

  always @(posedge clk) begin
    fat_rsp_t e, a;
    if (rst_n && out_valid && !out_stall) begin
      a = '{out_byte_out, out_entry_out, out_freed_count, out_status};
      if (rsp_pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result %h", a);
      end else begin
        e = rsp_pending.pop_front();
        if (e !== a) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp byte %h entry %h freed %h st %b / got %h %h %h %b",
                     e.bout, e.eout, e.freed, e.st, a.bout, a.eout, a.freed, a.st);
        end
      end
    end
  end

  // low table region is written first; random requests stay inside it
  task automatic test_table_fill();
    for (int a = 0; a < FillBytes; a++) issue(CMD_WR_BYTE, a, 0);
  endtask

  task automatic test_directed();
    int unsigned c;
    issue(CMD_WR_BYTE, TableBytes - 1, 'hFF);
    issue(CMD_RD_BYTE, TableBytes - 1);
    issue(CMD_RD_BYTE, 0);
    issue(CMD_WR_BYTE, 6141, 0);
    issue(CMD_WR_BYTE, 6142, 0);
    issue(CMD_WR_BYTE, 6143, 0);
    issue(CMD_SET, 0, 0, 4095, 'hFFF);
    issue(CMD_GET, 0, 0, 4095);
    issue(CMD_SET, 0, 0, 4094, 'hABC);
    issue(CMD_GET, 0, 0, 4094);
    issue(CMD_GET, 0, 0, 0);
    issue(CMD_ALLOC, 0, 0, 0);
    c = lowest_free();
    issue(CMD_ALLOC, 0, 0, c);
    issue(CMD_GET, 0, 0, c);
    issue(CMD_SET, 0, 0, 10, 11);
    issue(CMD_SET, 0, 0, 11, 10);
    issue(CMD_FREE, 0, 0, 10);
    issue(CMD_FREE, 0, 0, 1);
    issue(CMD_FREE, 0, 0, 0);
    issue(CMD_FREE, 0, 0, 'hFF8);
    issue(CMD_FREE, 0, 0, 2);
    issue(CMD_FREE, 0, 0, c);
    issue(CmdSpareA, 5, 7, 9, 9);
    issue(CmdSpareB, 'h1FFF, 'hFF, 'hFFF, 'hFFF);
  endtask

  task automatic test_limits();
    write_limit(3);
    issue(CMD_ALLOC, 0, 0, 0);
    issue(CMD_ALLOC, 0, 0, 0);
    write_limit(2);
    issue(CMD_ALLOC, 0, 0, 0);
    issue(CMD_FREE, 0, 0, 2);
    write_limit(4095);
    issue(CMD_ALLOC, 0, 0, 0);
    issue(CMD_FREE, 0, 0, 2);
    write_limit(LimitReset);
  endtask

  task automatic random_req();
    fat_rsp_t    p;
    fat_req_t    r;
    int unsigned k;
    r.cmd  = 3'($urandom_range(7));
    r.addr = 13'($urandom_range(FillBytes - 1));
    r.bval = 8'($urandom_range(255));
    r.clus = 12'($urandom_range(FillClusters - 1));
    r.eval = 12'($urandom_range(4095));
    k = $urandom_range(99);
    if (k < 8) r.cmd = CMD_RD_BYTE;
    else if (k < 12) r.cmd = CMD_WR_BYTE;
    else if (k < 28) r.cmd = CMD_GET;
    else if (k < 38) r.cmd = CMD_SET;
    else if (k < 70) begin
      r.cmd = CMD_ALLOC;
      r.clus = 12'(chain_tail);
    end else if (k < 84 || chain_len > 24) begin
      r.cmd = CMD_FREE;
      r.clus = 12'(chain_head);
    end
    if (r.cmd == CMD_FREE && !walk_safe(r.clus)) r.cmd = CMD_GET;
    if (r.cmd == CMD_ALLOC && !alloc_safe()) r.cmd = CMD_GET;
    send_req(r, p);
    if (r.cmd == CMD_ALLOC && k >= 38 && k < 70 && !p.st) begin
      if (chain_tail == 0) chain_head = p.eout;
      chain_tail = p.eout;
      chain_len++;
    end else if (r.cmd == CMD_FREE && r.clus == chain_head) begin
      chain_head = 0;
      chain_tail = 0;
      chain_len = 0;
    end
  endtask

  task automatic test_random();
    int unsigned lims [5] = '{LimitReset, 3, 40, 4095, 0};
    lims[4] = $urandom_range(3, 4088);
    for (int ph = 0; ph < 5; ph++) begin
      write_limit(lims[ph]);
      chain_head = 0;
      chain_tail = 0;
      chain_len = 0;
      for (int i = 0; i < 225; i++) begin
        steady = (ph == 2 && i < 150);
        random_req();
      end
      steady = 1'b0;
    end
  endtask

  task automatic test_backpressure();
    hold_req = 1'b1;
    for (int i = 0; i < 30; i++) random_req();
  endtask

  initial begin
    rst_n <= 1'b0;
    in_valid <= 1'b0;
    in_command <= CMD_RD_BYTE;
    in_byte_addr <= '0;
    in_byte_in <= '0;
    in_cluster <= '0;
    in_entry_value <= '0;
    cfg_we <= 1'b0;
    cfg_wdata <= '0;
    mismatches = 0;
    steady = 1'b0;
    hold_req = 1'b0;
    fat_limit = LimitReset;
    foreach (fat_bytes[i]) fat_bytes[i] = '0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_table_fill();
    test_directed();
    test_limits();
    test_random();
    test_backpressure();
    in_valid <= 1'b0;
    wait (rsp_pending.size() == 0);
    repeat (50) @(posedge clk);
    if (mismatches == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  initial begin
    #300000000;
    $display("CHECKS FAILED");
    $finish;
  end
endmodule
